// ===== hw/rtl/isc_pkg.sv =====
// Shared types and constants for the image scaler.
// Used by every module of the block but isc_ram; depends on nothing.
package isc_pkg;

  localparam int CHAN_W    = 16;  // Q8.8 colour channel
  localparam int SUM_W     = 20;  // block sum of up to sixteen channels
  localparam int COORD_W   = 14;  // result coordinate
  localparam int ROW_W     = 11;  // input row counter
  localparam int CFG_DIM_W = 12;  // width and height registers
  localparam int FACT_W    = 4;   // up factor register
  localparam int CNT_W     = 3;   // copy counter inside one pixel square
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_DIM_W-1:0] ROW_LIMIT     = 12'd2048;
  localparam logic [FACT_W-1:0]    MAX_UP_FACTOR = 4'd8;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP_FACTOR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

  // Scale mode codes.
  localparam logic [MODE_W-1:0] MODE_HALF    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUARTER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UP      = 2'd2;

  localparam logic [MODE_W-1:0]    RST_SCALE_MODE   = MODE_HALF;
  localparam logic [FACT_W-1:0]    RST_UP_FACTOR    = 4'd2;
  localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT = 12'd480;

  // One result square handed from the line-sum stage to the output sequencer.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CNT_W-1:0]   fm1;  // copies per side minus one
  } res_t;

endpackage

// ===== hw/rtl/isc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package needed.
module isc_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/isc_front.sv =====
// Configuration registers, pixel position counters and the block-sum stage.
// Uses isc_pkg and one isc_ram instance as the line store of block sums.
module isc_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [isc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [isc_pkg::CFG_DIM_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [isc_pkg::CHAN_W-1:0]        in_red,
  input  logic [isc_pkg::CHAN_W-1:0]        in_green,
  input  logic [isc_pkg::CHAN_W-1:0]        in_blue,
  output logic                              res_valid,
  input  logic                              res_ready,
  output isc_pkg::res_t                     res
);
  import isc_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int IDX_W  = COL_W - 1;
  localparam int DEPTH  = MAX_WIDTH / 2;
  localparam int DIM_W  = (COL_W + 1 > CFG_DIM_W) ? COL_W + 1 : CFG_DIM_W;
  localparam int XP_W   = COL_W + FACT_W;
  localparam int YP_W   = ROW_W + FACT_W;
  localparam int LINE_W = 3 * SUM_W;

  logic [MODE_W-1:0]    scale_mode;
  logic [FACT_W-1:0]    up_factor;
  logic [CFG_DIM_W-1:0] image_width;
  logic [CFG_DIM_W-1:0] image_height;
  logic [COL_W-1:0]     col;
  logic [ROW_W-1:0]     row;

  // Input-side decode.
  logic                 in_acc;
  logic [DIM_W-1:0]     width_ext;
  logic [DIM_W-1:0]     w_eff;
  logic [CFG_DIM_W-1:0] h_eff;
  logic [DIM_W-1:0]     col_inc;
  logic [CFG_DIM_W-1:0] row_inc;
  logic                 is_up;
  logic                 is_quad;
  logic [1:0]           lo_mask;
  logic [1:0]           x_lo;
  logic [1:0]           y_lo;
  logic                 x_in;
  logic                 y_in;
  logic [FACT_W-1:0]    f_eff;
  logic [XP_W-1:0]      xprod;
  logic [YP_W-1:0]      yprod;
  logic [IDX_W-1:0]     idx0;
  logic                 emit0;
  logic [COORD_W-1:0]   bx0;
  logic [COORD_W-1:0]   by0;

  // Sum stage.
  logic                 v1;
  logic                 write1;
  logic                 first1;
  logic                 emit1;
  logic                 quad1;
  logic [IDX_W-1:0]     idx1;
  logic [CHAN_W-1:0]    red1;
  logic [CHAN_W-1:0]    green1;
  logic [CHAN_W-1:0]    blue1;
  logic [COORD_W-1:0]   bx1;
  logic [COORD_W-1:0]   by1;
  logic [CNT_W-1:0]     fm1_1;
  logic                 fwd1;
  logic [SUM_W-1:0]     fwd_red;
  logic [SUM_W-1:0]     fwd_green;
  logic [SUM_W-1:0]     fwd_blue;
  logic                 s1_adv;
  logic                 ram_we;
  logic [LINE_W-1:0]    ram_q;
  logic [SUM_W-1:0]     base_red;
  logic [SUM_W-1:0]     base_green;
  logic [SUM_W-1:0]     base_blue;
  logic [SUM_W-1:0]     sum_red;
  logic [SUM_W-1:0]     sum_green;
  logic [SUM_W-1:0]     sum_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mode   <= RST_SCALE_MODE;
      up_factor    <= RST_UP_FACTOR;
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCALE_MODE:   scale_mode   <= cfg_data[MODE_W-1:0];
        REG_UP_FACTOR:    up_factor    <= cfg_data[FACT_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_comb begin
    width_ext = DIM_W'(image_width);
    if (width_ext == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_ext > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
    if (image_height == '0) begin
      h_eff = CFG_DIM_W'(1);
    end else if (image_height > ROW_LIMIT) begin
      h_eff = ROW_LIMIT;
    end else begin
      h_eff = image_height;
    end
    if (up_factor == '0) begin
      f_eff = FACT_W'(1);
    end else if (up_factor > MAX_UP_FACTOR) begin
      f_eff = MAX_UP_FACTOR;
    end else begin
      f_eff = up_factor;
    end

    col_inc = DIM_W'(col) + DIM_W'(1);
    row_inc = CFG_DIM_W'(row) + CFG_DIM_W'(1);

    // Mode three falls in with the quarter mode.
    is_up   = (scale_mode == MODE_UP);
    is_quad = !is_up && (scale_mode != MODE_HALF);
    lo_mask = is_quad ? 2'b11 : 2'b01;
    x_lo    = col[1:0] & lo_mask;
    y_lo    = row[1:0] & lo_mask;

    // When downscaling, only complete blocks inside the image produce a result.
    x_in  = DIM_W'(col) < (w_eff & ~DIM_W'(lo_mask));
    y_in  = CFG_DIM_W'(row) < (h_eff & ~CFG_DIM_W'(lo_mask));
    emit0 = (x_lo == lo_mask) && (y_lo == lo_mask) && x_in && y_in;
    idx0  = is_quad ? IDX_W'(col >> 2) : IDX_W'(col >> 1);

    xprod = XP_W'(col) * XP_W'(f_eff);
    yprod = YP_W'(row) * YP_W'(f_eff);
    if (is_up) begin
      bx0 = COORD_W'(xprod);
      by0 = COORD_W'(yprod);
    end else if (is_quad) begin
      bx0 = COORD_W'(col >> 2);
      by0 = COORD_W'(row >> 2);
    end else begin
      bx0 = COORD_W'(col >> 1);
      by0 = COORD_W'(row >> 1);
    end
  end

  assign s1_adv   = v1 && (!emit1 || res_ready);
  assign in_ready = !v1 || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_acc) begin
      if (col_inc >= w_eff) begin
        col <= '0;
        row <= (row_inc >= h_eff) ? '0 : ROW_W'(row_inc);
      end else begin
        col <= COL_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_acc) begin
      v1 <= 1'b1;
    end else if (s1_adv) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      write1 <= !is_up;
      first1 <= (x_lo == 2'b00) && (y_lo == 2'b00);
      emit1  <= is_up || emit0;
      quad1  <= is_quad;
      idx1   <= idx0;
      red1   <= in_red;
      green1 <= in_green;
      blue1  <= in_blue;
      bx1    <= bx0;
      by1    <= by0;
      fm1_1  <= is_up ? CNT_W'(f_eff - FACT_W'(1)) : '0;
      // The sum being written this cycle is not yet visible in the next read.
      fwd1      <= ram_we && !is_up && (idx1 == idx0);
      fwd_red   <= sum_red;
      fwd_green <= sum_green;
      fwd_blue  <= sum_blue;
    end
  end

  always_comb begin
    base_red   = fwd1 ? fwd_red   : ram_q[3*SUM_W-1:2*SUM_W];
    base_green = fwd1 ? fwd_green : ram_q[2*SUM_W-1:SUM_W];
    base_blue  = fwd1 ? fwd_blue  : ram_q[SUM_W-1:0];
    if (first1) begin
      sum_red   = SUM_W'(red1);
      sum_green = SUM_W'(green1);
      sum_blue  = SUM_W'(blue1);
    end else begin
      sum_red   = base_red   + SUM_W'(red1);
      sum_green = base_green + SUM_W'(green1);
      sum_blue  = base_blue  + SUM_W'(blue1);
    end
  end

  assign ram_we = v1 && write1 && s1_adv;

  isc_ram #(
    .WIDTH(LINE_W),
    .DEPTH(DEPTH)
  ) u_line (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx1),
    .wdata({sum_red, sum_green, sum_blue}),
    .re   (in_acc && !is_up),
    .raddr(idx0),
    .rdata(ram_q)
  );

  assign res_valid = v1 && emit1;

  always_comb begin
    res.x   = bx1;
    res.y   = by1;
    res.fm1 = fm1_1;
    if (!write1) begin
      res.red   = red1;
      res.green = green1;
      res.blue  = blue1;
    end else if (quad1) begin
      res.red   = sum_red[SUM_W-1:4];
      res.green = sum_green[SUM_W-1:4];
      res.blue  = sum_blue[SUM_W-1:4];
    end else begin
      res.red   = sum_red[CHAN_W+1:2];
      res.green = sum_green[CHAN_W+1:2];
      res.blue  = sum_blue[CHAN_W+1:2];
    end
  end

endmodule

// ===== hw/rtl/isc_emit.sv =====
// Output sequencer: registers each result and walks the copy square of an
// upscaled pixel row by row. Uses isc_pkg.
module isc_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          res_valid,
  output logic                          res_ready,
  input  isc_pkg::res_t                 res,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [isc_pkg::COORD_W-1:0]   out_x,
  output logic [isc_pkg::COORD_W-1:0]   out_y,
  output logic [isc_pkg::CHAN_W-1:0]    out_red,
  output logic [isc_pkg::CHAN_W-1:0]    out_green,
  output logic [isc_pkg::CHAN_W-1:0]    out_blue,
  output logic                          out_last
);
  import isc_pkg::*;

  logic [COORD_W-1:0] base_x;
  logic [CNT_W-1:0]   ii;
  logic [CNT_W-1:0]   jj;
  logic [CNT_W-1:0]   fm1;
  logic [CNT_W-1:0]   ii_next;
  logic [CNT_W-1:0]   jj_next;
  logic               load;
  logic               step;

  assign res_ready = !out_valid || (out_ready && out_last);
  assign load      = res_valid && res_ready;
  assign step      = out_valid && out_ready && !out_last;

  always_comb begin
    if (ii == fm1) begin
      ii_next = '0;
      jj_next = jj + CNT_W'(1);
    end else begin
      ii_next = ii + CNT_W'(1);
      jj_next = jj;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready && out_last) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_x     <= res.x;
      out_y     <= res.y;
      base_x    <= res.x;
      out_red   <= res.red;
      out_green <= res.green;
      out_blue  <= res.blue;
      fm1       <= res.fm1;
      ii        <= '0;
      jj        <= '0;
      out_last  <= (res.fm1 == '0);
    end else if (step) begin
      ii       <= ii_next;
      jj       <= jj_next;
      out_last <= (ii_next == fm1) && (jj_next == fm1);
      if (ii == fm1) begin
        out_x <= base_x;
        out_y <= out_y + COORD_W'(1);
      end else begin
        out_x <= out_x + COORD_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/image_box_down_nearest_up_scaler_unit.sv =====
// Image scaler: 2x2 or 4x4 box-mean downscale, or nearest-neighbor upscale.
// A result passes through the sum-stage register and then the output register.
// Throughput: one pixel per cycle when downscaling while the output is not stalled;
// an upscaled pixel is sent as f*f copies, one copy per cycle while out_ready is high.
// Reset clears the position counters and pipeline valids and loads default
// registers; the line store of block sums needs no clearing.
module image_box_down_nearest_up_scaler_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [isc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [isc_pkg::CFG_DIM_W-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [isc_pkg::CHAN_W-1:0]      in_red,
  input  logic [isc_pkg::CHAN_W-1:0]      in_green,
  input  logic [isc_pkg::CHAN_W-1:0]      in_blue,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [isc_pkg::COORD_W-1:0]     out_x,
  output logic [isc_pkg::COORD_W-1:0]     out_y,
  output logic [isc_pkg::CHAN_W-1:0]      out_red,
  output logic [isc_pkg::CHAN_W-1:0]      out_green,
  output logic [isc_pkg::CHAN_W-1:0]      out_blue,
  output logic                            out_last
);
  import isc_pkg::*;

  logic res_valid;
  logic res_ready;
  res_t res;

  isc_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  isc_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_red  (out_red),
    .out_green(out_green),
    .out_blue (out_blue),
    .out_last (out_last)
  );

endmodule

// ===== hw/rtl/isc_checker.sv =====
// Port-level checks for the image scaler, bound to its top level.
// Uses isc_pkg for field widths.
module isc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [isc_pkg::COORD_W-1:0]   out_x,
  input logic [isc_pkg::COORD_W-1:0]   out_y,
  input logic                          out_last
);
  import isc_pkg::*;

  // A stalled result beat keeps its coordinates.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y))
    else $error("stalled result beat changed");

  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat shown right after reset");

  // The copies of one pixel follow each other without a gap.
  a_copy_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("copy sequence broke off before its last beat");

  a_copy_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=>
      (out_y == $past(out_y)) || (out_y == $past(out_y) + COORD_W'(1)))
    else $error("copy row jumped by more than one");

  // An empty output register never holds back the input.
  a_in_open: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

bind image_box_down_nearest_up_scaler_unit isc_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_x    (out_x),
  .out_y    (out_y),
  .out_last (out_last)
);
